// File: src/wdg_pkg.sv
// Package for the window hit and drag engine: sizes, codes, slot record,
// controller state and the command/status structs. No dependencies.
package wdg_pkg;

	localparam int MAX_WINDOWS = 16;
	localparam int SLOT_BITS   = $clog2(MAX_WINDOWS);
	localparam int ID_BITS     = SLOT_BITS + 1;
	localparam int COORD_BITS  = 12;
	localparam int POS_BITS    = COORD_BITS + 1;
	localparam int OFF_BITS    = COORD_BITS + 2;
	localparam int GEO_BITS    = COORD_BITS + 4;
	localparam int CFG_BITS    = 12;
	localparam int CIDX_BITS   = 3;

	localparam logic [ID_BITS-1:0] NONE_ID = ID_BITS'(MAX_WINDOWS);

	localparam logic [1:0] OP_MOUSE   = 2'd0;
	localparam logic [1:0] OP_CREATE  = 2'd1;
	localparam logic [1:0] OP_DESTROY = 2'd2;

	localparam logic [CIDX_BITS-1:0] CFG_BORDER = 3'd0;
	localparam logic [CIDX_BITS-1:0] CFG_TITLE  = 3'd1;
	localparam logic [CIDX_BITS-1:0] CFG_BSIZE  = 3'd2;
	localparam logic [CIDX_BITS-1:0] CFG_MARGIN = 3'd3;
	localparam logic [CIDX_BITS-1:0] CFG_SCR_W  = 3'd4;
	localparam logic [CIDX_BITS-1:0] CFG_WORK_H = 3'd5;

	typedef enum logic [3:0] {
		EV_NONE, EV_CLOSED, EV_CLIENT, EV_DRAG_START, EV_DRAG_MOVE,
		EV_DRAG_END, EV_CREATED, EV_FULL, EV_DESTROYED, EV_NO_WIN
	} event_t;

	typedef enum logic [1:0] {AREA_NONE, AREA_TITLE, AREA_CLOSE, AREA_CLIENT} hit_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CREATE, ST_DESTROY, ST_SCAN, ST_SCAN_TAIL, ST_ACT,
		ST_DRAG_CHK, ST_DRAG_PL, ST_REL, ST_FINISH
	} state_t;

	typedef struct packed {
		logic [POS_BITS-1:0]   left;
		logic [POS_BITS-1:0]   top;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
		logic                  shown;
		logic                  close;
		logic [SLOT_BITS-1:0]  z;
	} rec_t;

	typedef struct packed {
		logic accept;
		logic create;
		logic destroy;
		logic scan_rd;
		logic act;
		logic drag_rd;
		logic drag_place;
		logic release_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       click;
		logic       scan_last;
		logic       drag_on;
		logic       out_free;
	} sts_t;

endpackage

// File: src/wdg_if.sv
// Request and response channel interfaces of the window engine.
// Depends on wdg_pkg for field widths.
interface wdg_req_if import wdg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [1:0]            op;
	logic [COORD_BITS-1:0] mouse_x;
	logic [COORD_BITS-1:0] mouse_y;
	logic                  button;
	logic [POS_BITS-1:0]   win_x;
	logic [POS_BITS-1:0]   win_y;
	logic [COORD_BITS-1:0] win_w;
	logic [COORD_BITS-1:0] win_h;
	logic                  visible;
	logic                  has_close;
	logic [SLOT_BITS-1:0]  target_id;
	modport source (output valid, op, mouse_x, mouse_y, button, win_x, win_y,
		win_w, win_h, visible, has_close, target_id, input ready);
	modport sink (input valid, op, mouse_x, mouse_y, button, win_x, win_y,
		win_w, win_h, visible, has_close, target_id, output ready);
endinterface

interface wdg_rsp_if import wdg_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [3:0]          event_res;
	logic [ID_BITS-1:0]  window_id;
	logic [POS_BITS-1:0] rel_x;
	logic [POS_BITS-1:0] rel_y;
	logic [POS_BITS-1:0] pos_x;
	logic [POS_BITS-1:0] pos_y;
	logic [ID_BITS-1:0]  focus_id;
	logic                redraw;
	logic [ID_BITS-1:0]  open_count;
	modport source (output valid, event_res, window_id, rel_x, rel_y, pos_x, pos_y,
		focus_id, redraw, open_count, input ready);
	modport sink (input valid, event_res, window_id, rel_x, rel_y, pos_x, pos_y,
		focus_id, redraw, open_count, output ready);
endinterface

// File: src/wdg_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module wdg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// File: src/wdg_ctrl.sv
// Controller state machine of the window engine: sequences create, destroy,
// press scan, drag and release steps. Depends on wdg_pkg.
module wdg_ctrl import wdg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_ready
);
	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (sts.op == OP_CREATE) state_nx = ST_CREATE;
					else if (sts.op == OP_DESTROY) state_nx = ST_DESTROY;
					else if (sts.click) state_nx = ST_SCAN;
					else state_nx = ST_DRAG_CHK;
				end
			end
			ST_CREATE:    state_nx = ST_FINISH;
			ST_DESTROY:   state_nx = ST_FINISH;
			ST_SCAN:      if (sts.scan_last) state_nx = ST_SCAN_TAIL;
			ST_SCAN_TAIL: state_nx = ST_ACT;
			ST_ACT:       state_nx = ST_DRAG_CHK;
			ST_DRAG_CHK:  state_nx = sts.drag_on ? ST_DRAG_PL : ST_REL;
			ST_DRAG_PL:   state_nx = ST_REL;
			ST_REL:       state_nx = ST_FINISH;
			ST_FINISH:    if (sts.out_free) state_nx = ST_IDLE;
			default:      state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = req_valid;
			end
			ST_CREATE:   cmd.create = 1'b1;
			ST_DESTROY:  cmd.destroy = 1'b1;
			ST_SCAN:     cmd.scan_rd = 1'b1;
			ST_ACT:      cmd.act = 1'b1;
			ST_DRAG_CHK: cmd.drag_rd = sts.drag_on;
			ST_DRAG_PL:  cmd.drag_place = 1'b1;
			ST_REL:      cmd.release_step = 1'b1;
			ST_FINISH:   cmd.finish = sts.out_free;
			default: ;
		endcase
	end
endmodule

// File: src/wdg_dp.sv
// Datapath of the window engine: config registers, slot table RAM, valid
// bits, hit scan, drag clamp and output register. Depends on wdg_pkg, wdg_if, wdg_ram.
module wdg_dp import wdg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CIDX_BITS-1:0] cfg_idx,
	input  logic [CFG_BITS-1:0]  cfg_data,
	wdg_req_if.sink              req,
	wdg_rsp_if.source            rsp,
	input  cmd_t                 cmd,
	output sts_t                 sts
);
	// config
	logic [3:0]            border_q;
	logic [5:0]            title_q, bsize_q;
	logic [4:0]            margin_q;
	logic [COORD_BITS-1:0] scr_w_q, work_h_q;
	// item
	logic [COORD_BITS-1:0] mx_q, my_q, ww_q, wh_q;
	logic                  btn_q, vis_q, hc_q;
	logic [POS_BITS-1:0]   wx_q, wy_q;
	logic [SLOT_BITS-1:0]  tgt_q;
	// table state
	logic [MAX_WINDOWS-1:0] valid_q;
	logic [ID_BITS-1:0]     open_q, focus_q, drag_q;
	logic [OFF_BITS-1:0]    offx_q, offy_q;
	logic                   btn_before_q;
	// scan
	logic [SLOT_BITS-1:0]  cnt_q, idx_s1;
	logic                  eval_s1;
	logic [ID_BITS-1:0]    best_id_q;
	logic [SLOT_BITS-1:0]  best_z_q;
	hit_t                  best_hit_q;
	logic [POS_BITS-1:0]   best_left_q, best_top_q;
	// result
	event_t                ev_q;
	logic [ID_BITS-1:0]    wid_q;
	logic [POS_BITS-1:0]   rx_q, ry_q, px_q, py_q;
	logic                  rd_q;
	// output register
	logic                  out_valid_q;
	event_t                o_ev_q;
	logic [ID_BITS-1:0]    o_wid_q, o_focus_q, o_open_q;
	logic [POS_BITS-1:0]   o_rx_q, o_ry_q, o_px_q, o_py_q;
	logic                  o_rd_q;

	rec_t                  rdata, wdata, new_rec;
	logic                  we;
	logic [SLOT_BITS-1:0]  addr, drag_idx;
	logic [ID_BITS-1:0]    free_id;
	logic                  full, drag_ok;
	hit_t                  scan_hit;
	logic signed [GEO_BITS-1:0] m_x, m_y, nx, ny, t_x, t_y, sw_e, wh_e, w_e, h_e;
	logic signed [GEO_BITS-1:0] bl_e, bt_e, dx, dy, relx, rely, offx_e, offy_e;

	function automatic logic signed [GEO_BITS-1:0] sx(input logic [POS_BITS-1:0] v);
		sx = {{(GEO_BITS-POS_BITS){v[POS_BITS-1]}}, v};
	endfunction

	function automatic logic signed [GEO_BITS-1:0] zx(input logic [COORD_BITS-1:0] v);
		zx = {{(GEO_BITS-COORD_BITS){1'b0}}, v};
	endfunction

	function automatic hit_t classify(input rec_t r, input logic [COORD_BITS-1:0] mxv,
		input logic [COORD_BITS-1:0] myv, input logic [3:0] bd, input logic [5:0] th,
		input logic [5:0] bs, input logic [4:0] bm);
		logic signed [GEO_BITS-1:0] x, y, xr, yb, px, py, d, d1, half, bx, by, bxe, bye;
		logic signed [GEO_BITS-1:0] bde, bse, bme, the, ty;
		x   = sx(r.left);
		y   = sx(r.top);
		px  = zx(mxv);
		py  = zx(myv);
		bde = {{(GEO_BITS-4){1'b0}}, bd};
		bse = {{(GEO_BITS-6){1'b0}}, bs};
		bme = {{(GEO_BITS-5){1'b0}}, bm};
		the = {{(GEO_BITS-6){1'b0}}, th};
		xr  = x + zx(r.w);
		yb  = y + zx(r.h);
		d   = the - bse;
		// halve, rounding toward zero
		d1  = d + {{(GEO_BITS-1){1'b0}}, d[GEO_BITS-1]};
		half = d1 >>> 1;
		bx  = xr - bde - bse - bme;
		by  = y + bde + half;
		bxe = bx + bse;
		bye = by + bse;
		ty  = y + bde + the;
		if (px < x || px >= xr || py < y || py >= yb) classify = AREA_NONE;
		else if (r.close && px >= bx && px < bxe && py >= by && py < bye) classify = AREA_CLOSE;
		else if (py < ty) classify = AREA_TITLE;
		else classify = AREA_CLIENT;
	endfunction

	wdg_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_WINDOWS)) u_ram (
		.clk  (clk),
		.we   (we),
		.addr (addr),
		.wdata(wdata),
		.rdata(rdata)
	);

	always_comb begin
		free_id = NONE_ID;
		for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_id = ID_BITS'(i);
		end
	end

	assign full     = (open_q >= NONE_ID) || (free_id == NONE_ID);
	assign drag_idx = drag_q[SLOT_BITS-1:0];
	assign drag_ok  = (drag_q != NONE_ID);

	assign new_rec = '{left: wx_q, top: wy_q, w: ww_q, h: wh_q, shown: vis_q,
		close: hc_q, z: open_q[SLOT_BITS-1:0]};

	// clamp of dragged window
	always_comb begin
		m_x    = zx(mx_q);
		m_y    = zx(my_q);
		offx_e = {{(GEO_BITS-OFF_BITS){offx_q[OFF_BITS-1]}}, offx_q};
		offy_e = {{(GEO_BITS-OFF_BITS){offy_q[OFF_BITS-1]}}, offy_q};
		w_e    = zx(rdata.w);
		h_e    = zx(rdata.h);
		sw_e   = zx(scr_w_q);
		wh_e   = zx(work_h_q);
		nx     = m_x - offx_e;
		ny     = m_y - offy_e;
		if (nx < 0) nx = '0;
		if (ny < 0) ny = '0;
		t_x    = nx + w_e;
		t_y    = ny + h_e;
		if (t_x > sw_e) nx = sw_e - w_e;
		if (t_y > wh_e) ny = wh_e - h_e;
		bl_e   = sx(best_left_q);
		bt_e   = sx(best_top_q);
		dx     = m_x - bl_e;
		dy     = m_y - bt_e;
		relx   = m_x - (bl_e + {{(GEO_BITS-4){1'b0}}, border_q});
		rely   = m_y - (bt_e + {{(GEO_BITS-4){1'b0}}, border_q}
			+ {{(GEO_BITS-6){1'b0}}, title_q});
	end

	always_comb begin
		we    = 1'b0;
		addr  = cnt_q;
		wdata = rdata;
		if (cmd.create) begin
			we    = !full;
			addr  = free_id[SLOT_BITS-1:0];
			wdata = new_rec;
		end else if (cmd.drag_rd || cmd.drag_place) begin
			addr  = drag_idx;
			we    = cmd.drag_place && valid_q[drag_idx];
			wdata.left = nx[POS_BITS-1:0];
			wdata.top  = ny[POS_BITS-1:0];
		end
	end

	assign scan_hit = classify(rdata, mx_q, my_q, border_q, title_q, bsize_q, margin_q);

	assign sts.op        = req.op;
	assign sts.click     = req.button && !btn_before_q;
	assign sts.scan_last = (cnt_q == SLOT_BITS'(MAX_WINDOWS - 1));
	assign sts.drag_on   = drag_ok && btn_q;
	assign sts.out_free  = !out_valid_q || rsp.ready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_q     <= 4'd2;
			title_q      <= 6'd24;
			bsize_q      <= 6'd16;
			margin_q     <= 5'd4;
			scr_w_q      <= 12'd1024;
			work_h_q     <= 12'd736;
			valid_q      <= '0;
			open_q       <= '0;
			focus_q      <= NONE_ID;
			drag_q       <= NONE_ID;
			offx_q       <= '0;
			offy_q       <= '0;
			btn_before_q <= 1'b0;
			cnt_q        <= '0;
			eval_s1      <= 1'b0;
			best_id_q    <= NONE_ID;
			best_z_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_BORDER: border_q <= cfg_data[3:0];
					CFG_TITLE:  title_q  <= cfg_data[5:0];
					CFG_BSIZE:  bsize_q  <= cfg_data[5:0];
					CFG_MARGIN: margin_q <= cfg_data[4:0];
					CFG_SCR_W:  scr_w_q  <= cfg_data;
					CFG_WORK_H: work_h_q <= cfg_data;
					default: ;
				endcase
			end
			eval_s1 <= cmd.scan_rd;
			if (cmd.accept) begin
				cnt_q     <= '0;
				best_id_q <= NONE_ID;
				best_z_q  <= '0;
			end
			if (cmd.scan_rd) cnt_q <= cnt_q + 1'b1;
			if (eval_s1 && valid_q[idx_s1] && rdata.shown && scan_hit != AREA_NONE
					&& rdata.z >= best_z_q) begin
				best_id_q <= {1'b0, idx_s1};
				best_z_q  <= rdata.z;
			end
			if (cmd.create && !full) begin
				valid_q[free_id[SLOT_BITS-1:0]] <= 1'b1;
				open_q  <= open_q + 1'b1;
				focus_q <= free_id;
			end
			if (cmd.destroy && ({1'b0, tgt_q} < NONE_ID) && valid_q[tgt_q]) begin
				valid_q[tgt_q] <= 1'b0;
				if (open_q != '0) open_q <= open_q - 1'b1;
				if (focus_q == {1'b0, tgt_q}) focus_q <= NONE_ID;
			end
			if (cmd.act && best_id_q != NONE_ID) begin
				unique case (best_hit_q)
					AREA_CLOSE: begin
						valid_q[best_id_q[SLOT_BITS-1:0]] <= 1'b0;
						if (open_q != '0) open_q <= open_q - 1'b1;
						focus_q <= NONE_ID;
					end
					AREA_TITLE: begin
						focus_q <= best_id_q;
						drag_q  <= best_id_q;
						offx_q  <= dx[OFF_BITS-1:0];
						offy_q  <= dy[OFF_BITS-1:0];
					end
					default: focus_q <= best_id_q;
				endcase
			end
			if (cmd.release_step) begin
				btn_before_q <= btn_q;
				if (!btn_q && btn_before_q && drag_ok) drag_q <= NONE_ID;
			end
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mx_q  <= req.mouse_x;
			my_q  <= req.mouse_y;
			btn_q <= req.button;
			wx_q  <= req.win_x;
			wy_q  <= req.win_y;
			ww_q  <= req.win_w;
			wh_q  <= req.win_h;
			vis_q <= req.visible;
			hc_q  <= req.has_close;
			tgt_q <= req.target_id;
			ev_q  <= EV_NONE;
			wid_q <= NONE_ID;
			rx_q  <= '0;
			ry_q  <= '0;
			px_q  <= '0;
			py_q  <= '0;
			rd_q  <= 1'b0;
		end
		idx_s1 <= cnt_q;
		if (eval_s1 && valid_q[idx_s1] && rdata.shown && scan_hit != AREA_NONE
				&& rdata.z >= best_z_q) begin
			best_hit_q  <= scan_hit;
			best_left_q <= rdata.left;
			best_top_q  <= rdata.top;
		end
		if (cmd.create) begin
			if (full) begin
				ev_q <= EV_FULL;
			end else begin
				ev_q  <= EV_CREATED;
				wid_q <= free_id;
				rd_q  <= 1'b1;
			end
		end
		if (cmd.destroy) begin
			wid_q <= {1'b0, tgt_q};
			if (({1'b0, tgt_q} < NONE_ID) && valid_q[tgt_q]) begin
				ev_q <= EV_DESTROYED;
				rd_q <= 1'b1;
			end else begin
				ev_q <= EV_NO_WIN;
			end
		end
		if (cmd.act && best_id_q != NONE_ID) begin
			wid_q <= best_id_q;
			unique case (best_hit_q)
				AREA_CLOSE: begin
					ev_q <= EV_CLOSED;
					rd_q <= 1'b1;
				end
				AREA_TITLE: ev_q <= EV_DRAG_START;
				default: begin
					ev_q <= EV_CLIENT;
					rd_q <= 1'b1;
					rx_q <= relx[POS_BITS-1:0];
					ry_q <= rely[POS_BITS-1:0];
				end
			endcase
		end
		if (cmd.drag_place) begin
			if (valid_q[drag_idx]) begin
				px_q <= nx[POS_BITS-1:0];
				py_q <= ny[POS_BITS-1:0];
			end
			if (ev_q != EV_DRAG_START) ev_q <= EV_DRAG_MOVE;
			wid_q <= drag_q;
			rd_q  <= 1'b1;
		end
		if (cmd.release_step && !btn_q && btn_before_q && drag_ok) begin
			ev_q  <= EV_DRAG_END;
			wid_q <= drag_q;
		end
		if (cmd.finish) begin
			o_ev_q    <= ev_q;
			o_wid_q   <= wid_q;
			o_rx_q    <= rx_q;
			o_ry_q    <= ry_q;
			o_px_q    <= px_q;
			o_py_q    <= py_q;
			o_focus_q <= focus_q;
			o_rd_q    <= rd_q;
			o_open_q  <= open_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.event_res  = o_ev_q;
	assign rsp.window_id  = o_wid_q;
	assign rsp.rel_x      = o_rx_q;
	assign rsp.rel_y      = o_ry_q;
	assign rsp.pos_x      = o_px_q;
	assign rsp.pos_y      = o_py_q;
	assign rsp.focus_id   = o_focus_q;
	assign rsp.redraw     = o_rd_q;
	assign rsp.open_count = o_open_q;
endmodule

// File: src/window_hit_and_drag_engine.sv
// Window hit and drag engine, top level.
// Steps per item: create or destroy, then finish; a mouse sample without press
// checks the drag, places the window while a drag is held, then releases; a press
// first scans all 16 slots, one RAM read a cycle, then acts on the hit. The result
// goes to the output register. One item at a time: requests are taken only in idle.
// Reset (arst_n low, async): no slots open, no focus, no drag, config defaults;
// the slot table RAM itself is not cleared, valid bits gate every read.
module window_hit_and_drag_engine import wdg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CIDX_BITS-1:0] cfg_idx,
	input  logic [CFG_BITS-1:0]  cfg_data,
	wdg_req_if.sink              req,
	wdg_rsp_if.source            rsp
);
	cmd_t cmd;   // controller -> datapath step commands
	sts_t sts;   // datapath -> controller status
	logic in_ready;

	// Controller: one state per step of an item; a transfer on req only in idle.
	wdg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	// Datapath: slot table, scan, clamp, result and output register.
	// The output register lets the next item start while a result waits.
	wdg_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.req     (req),
		.rsp     (rsp),
		.cmd     (cmd),
		.sts     (sts)
	);

	assign req.ready = in_ready;

`ifndef ASSERT_OFF
	// after a request transfer the engine is not ready in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while busy");

	// open count never exceeds the table size
	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.open_count <= NONE_ID))
		else $error("open count out of range");

	// a created window is the focused one
	a_create_focus: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.event_res == EV_CREATED) |-> (rsp.focus_id == rsp.window_id))
		else $error("created window not focused");

	// drag moves always request a redraw
	a_move_redraw: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.event_res == EV_DRAG_MOVE) |-> rsp.redraw)
		else $error("drag move without redraw");
`endif
endmodule
